// ===== rtl/aabb_frustum_cull_test_assert.svh =====
// Assertion macros for the frustum cull block.
// Used by aabb_frustum_cull_test, the only module that asserts.
`ifndef AABB_FRUSTUM_CULL_TEST_ASSERT_SVH
`define AABB_FRUSTUM_CULL_TEST_ASSERT_SVH
// a implies b on the same edge
`define AFC_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// a implies b on the following edge
`define AFC_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ===== rtl/afc_pkg.sv =====
// Package for the frustum cull block: sizes, op codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package afc_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_PLANES      = 6;
	localparam int NUM_CORNERS     = 8;
	localparam int FIELD_W         = 32;
	localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
	localparam logic [1:0] OP_LOAD_CORNER = 2'd1;
	localparam logic [1:0] OP_TEST        = 2'd2;
endpackage

// ===== rtl/afc_lane.sv =====
// One box-corner lane: plane dot product, registered in stages s1 and s2.
// Depends on afc_pkg.
`timescale 1ns / 1ps
module afc_lane #(
	parameter int CW = afc_pkg::COORD_WIDTH_DEF,
	parameter int FB = afc_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic signed [CW-1:0] pa,
	input  logic signed [CW-1:0] pb,
	input  logic signed [CW-1:0] pc,
	input  logic signed [CW-1:0] pd,
	input  logic signed [CW-1:0] x,
	input  logic signed [CW-1:0] y,
	input  logic signed [CW-1:0] z,
	output logic                 neg
);
	localparam int PW = 2 * CW;
	localparam int AW = PW + 3;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [AW-1:0] pd_s1;
	logic signed [AW-1:0] sum_s2;
	always_ff @(posedge clk) begin
		px_s1 <= pa * x;
		py_s1 <= pb * y;
		pz_s1 <= pc * z;
		pd_s1 <= AW'(pd) <<< FB;
		sum_s2 <= AW'(px_s1) + AW'(py_s1) + AW'(pz_s1) + pd_s1;
	end
	assign neg = sum_s2[AW-1];
endmodule

// ===== rtl/afc_merge.sv =====
// Merge stage: combines lane results per plane and the corner axis tests.
// Depends on afc_pkg.
`timescale 1ns / 1ps
module afc_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        lane_v,
	input  logic [afc_pkg::NUM_CORNERS-1:0] negs,
	input  logic                        last,
	input  logic                        axis_cull,
	output logic                        done,
	output logic                        vis
);
	logic cull_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_q <= 1'b0;
			done <= 1'b0;
			vis <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) cull_q <= 1'b0;
			if (lane_v) begin
				if (last) begin
					done <= 1'b1;
					vis <= !(cull_q || (&negs) || axis_cull);
					cull_q <= 1'b0;
				end else if (&negs) cull_q <= 1'b1;
			end
		end
	end
endmodule

// ===== rtl/aabb_frustum_cull_test.sv =====
// Top level of the box-versus-frustum cull test: stores, lanes, sequencer.
// Depends on afc_pkg, afc_lane, afc_merge and the assertion header.
//
// channel | direction | handshake    | payload
// in      | in        | valid, stall | op index value_a..value_f
// out     | out       | out_valid, out_stall | visible
// A test issues one plane per cycle over 8 lanes into a 2-stage lane pipe.
// Result beat follows the test beat via lanes and merge; the next test beat waits for it.
// Loads give no beat. Reset clears control, not stores.
// Input stalls while a test runs; a result that finds the last beat still
// waiting on out_stall is held and keeps the input stalled until it moves.
`timescale 1ns / 1ps
`include "aabb_frustum_cull_test_assert.svh"
module aabb_frustum_cull_test #(
	parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = afc_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  op,
	input  logic [2:0]  index,
	input  logic signed [31:0] value_a,
	input  logic signed [31:0] value_b,
	input  logic signed [31:0] value_c,
	input  logic signed [31:0] value_d,
	input  logic signed [31:0] value_e,
	input  logic signed [31:0] value_f,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        visible
);
	localparam int CW = COORD_WIDTH;
	localparam int NP = afc_pkg::NUM_PLANES;
	localparam int NC = afc_pkg::NUM_CORNERS;
	typedef logic signed [CW-1:0] crd_t;

	function automatic crd_t norm(input logic [31:0] f);
		logic [63:0] s;
		s = {{32{f[31]}}, f};
		return crd_t'(s[CW-1:0]);
	endfunction

	crd_t pl_a_q [NP], pl_b_q [NP], pl_c_q [NP], pl_d_q [NP];
	crd_t cx_q [NC], cy_q [NC], cz_q [NC];
	crd_t bmin_q [3], bmax_q [3];
	logic busy_q;
	logic [2:0] pidx_q;
	logic [1:0] v_s1;
	logic [1:0] l_s1;
	logic axis_q;
	logic pend_q, pend_vis_q;
	logic done, vis;

	wire acc = valid && !stall;
	wire issuing = busy_q && (pidx_q < 3'(NP));
	assign stall = busy_q;

	logic cull_ax;
	always_comb begin
		logic ab [3], be [3];
		crd_t v;
		for (int ax = 0; ax < 3; ax++) begin
			ab[ax] = 1'b1;
			be[ax] = 1'b1;
			for (int k = 0; k < NC; k++) begin
				v = (ax == 0) ? cx_q[k] : ((ax == 1) ? cy_q[k] : cz_q[k]);
				ab[ax] = ab[ax] && (bmax_q[ax] < v);
				be[ax] = be[ax] && (v < bmin_q[ax]);
			end
		end
		cull_ax = ab[0] || be[0] || ab[1] || be[1] || ab[2] || be[2];
	end

	always_ff @(posedge clk) begin
		if (acc && op == afc_pkg::OP_LOAD_PLANE && index < 3'(NP)) begin
			pl_a_q[index] <= norm(value_a);
			pl_b_q[index] <= norm(value_b);
			pl_c_q[index] <= norm(value_c);
			pl_d_q[index] <= norm(value_d);
		end
		if (acc && op == afc_pkg::OP_LOAD_CORNER) begin
			cx_q[index] <= norm(value_a);
			cy_q[index] <= norm(value_b);
			cz_q[index] <= norm(value_c);
		end
		if (acc && op == afc_pkg::OP_TEST) begin
			bmin_q[0] <= norm(value_a);
			bmin_q[1] <= norm(value_b);
			bmin_q[2] <= norm(value_c);
			bmax_q[0] <= norm(value_d);
			bmax_q[1] <= norm(value_e);
			bmax_q[2] <= norm(value_f);
		end
		if (busy_q && pidx_q == 3'd0) axis_q <= cull_ax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pidx_q <= 3'd0;
			v_s1 <= 2'd0;
			l_s1 <= 2'd0;
			pend_q <= 1'b0;
			pend_vis_q <= 1'b0;
			out_valid <= 1'b0;
			visible <= 1'b0;
		end else begin
			v_s1 <= {v_s1[0], issuing};
			l_s1 <= {l_s1[0], issuing && pidx_q == 3'(NP - 1)};
			if (acc && op == afc_pkg::OP_TEST) begin
				busy_q <= 1'b1;
				pidx_q <= 3'd0;
			end else if (issuing) pidx_q <= pidx_q + 3'd1;
			if (done) begin
				if (out_valid && out_stall) begin
					pend_q <= 1'b1;
					pend_vis_q <= vis;
				end else begin
					busy_q <= 1'b0;
					out_valid <= 1'b1;
					visible <= vis;
				end
			end else if (pend_q) begin
				if (!out_stall) begin
					pend_q <= 1'b0;
					busy_q <= 1'b0;
					visible <= pend_vis_q;
				end
			end else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	wire [2:0] pi = (pidx_q < 3'(NP)) ? pidx_q : 3'd0;
	logic [NC-1:0] negs;
	for (genvar k = 0; k < NC; k++) begin : g_lane
		afc_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane (
			.clk(clk), .pa(pl_a_q[pi]), .pb(pl_b_q[pi]), .pc(pl_c_q[pi]),
			.pd(pl_d_q[pi]),
			.x(k[0] ? bmax_q[0] : bmin_q[0]),
			.y(k[1] ? bmax_q[1] : bmin_q[1]),
			.z(k[2] ? bmax_q[2] : bmin_q[2]),
			.neg(negs[k])
		);
	end

	afc_merge u_merge (
		.clk(clk), .arst_n(arst_n), .start(acc && op == afc_pkg::OP_TEST),
		.lane_v(v_s1[1]), .negs(negs), .last(l_s1[1]), .axis_cull(axis_q),
		.done(done), .vis(vis)
	);

	`AFC_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy_q)
	`AFC_ASSERT_IMP(a_no_acc_busy, clk, arst_n, busy_q, stall)
	`AFC_ASSERT_NXT(a_done_out, clk, arst_n, done, out_valid)
	`AFC_ASSERT_IMP(a_idle_pipe, clk, arst_n, !busy_q, v_s1 == 2'd0)
endmodule
